// ===== hdl/tgv_pkg.sv =====
`timescale 1ns / 1ps

package tgv_pkg;

    localparam int MAX_DIVISIONS = 1024;
    localparam int DIV_W         = 11;
    localparam int NUM_W         = 27;
    localparam int QUOT_W        = 17;
    localparam int TAB_SEG       = 256;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_MAJOR   = 2'd2;
    localparam logic [1:0] REG_MINOR   = 2'd3;

    typedef logic [15:0] sine_tab_t [0:TAB_SEG];

    typedef struct packed {
        logic [15:0] a;
        logic [15:0] diff;
        logic [5:0]  frac;
        logic        neg;
    } lk_t;

    typedef struct packed {
        logic        in_range;
        logic [16:0] u16;
        logic [16:0] v16;
    } side_t;

    // quarter-wave sine, Q30 Taylor series, rounded to Q1.15
    function automatic sine_tab_t build_tab();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] q;
        for (int k = 0; k <= TAB_SEG; k++)
        begin
            x    = (64'd1686629713 * 64'(k)) >> 8;
            x2   = (x * x) >> 30;
            term = x;
            s    = x;
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    s = s - term;
                else
                    s = s + term;
            end
            q = (s + 64'd16384) >> 15;
            if (q > 64'd32767)
                q = 64'd32767;
            tab[k] = q[15:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_tab();

    function automatic lk_t sine_lookup(input logic [15:0] p);
        lk_t         r;
        logic [14:0] t;
        logic [8:0]  idx;
        if (p[14])
            t = 15'd16384 - {1'b0, p[13:0]};
        else
            t = {1'b0, p[13:0]};
        idx    = t[14:6];
        r.frac = t[5:0];
        r.neg  = p[15];
        if (idx[8])
        begin
            r.a    = SINE_TAB[TAB_SEG];
            r.diff = 16'd0;
        end
        else
        begin
            r.a    = SINE_TAB[idx[7:0]];
            r.diff = SINE_TAB[idx[7:0] + 9'd1] - SINE_TAB[idx[7:0]];
        end
        return r;
    endfunction

endpackage

// ===== hdl/tgv_div.sv =====
`timescale 1ns / 1ps

module tgv_div
(
    input  logic                            clk,
    input  logic                            en,
    input  logic [tgv_pkg::NUM_W-1:0]       dividend,
    input  logic [tgv_pkg::DIV_W-1:0]       divisor,
    output logic [tgv_pkg::QUOT_W-1:0]      quotient
);

    localparam int STEPS = tgv_pkg::QUOT_W;

    logic [tgv_pkg::DIV_W-1:0]  rem_reg  [0:STEPS-1];
    logic [tgv_pkg::NUM_W-1:0]  num_reg  [0:STEPS-1];
    logic [tgv_pkg::DIV_W-1:0]  dsr_reg  [0:STEPS-1];
    logic [tgv_pkg::QUOT_W-1:0] quot_reg [0:STEPS-1];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++)
        begin : g_step
            logic [tgv_pkg::DIV_W-1:0]  rem_in;
            logic [tgv_pkg::NUM_W-1:0]  num_in;
            logic [tgv_pkg::DIV_W-1:0]  dsr_in;
            logic [tgv_pkg::QUOT_W-1:0] quot_in;
            logic [tgv_pkg::DIV_W:0]    trial;
            logic                       take;

            if (k == 0)
            begin : g_first
                assign rem_in  = {1'b0, dividend[tgv_pkg::NUM_W-1:STEPS]};
                assign num_in  = dividend;
                assign dsr_in  = divisor;
                assign quot_in = '0;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[k-1];
                assign num_in  = num_reg[k-1];
                assign dsr_in  = dsr_reg[k-1];
                assign quot_in = quot_reg[k-1];
            end

            assign trial = {rem_in, num_in[STEPS-1-k]};
            assign take  = trial >= {1'b0, dsr_in};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= take ? (trial[tgv_pkg::DIV_W-1:0] - dsr_in)
                                        : trial[tgv_pkg::DIV_W-1:0];
                    num_reg[k]  <= num_in;
                    dsr_reg[k]  <= dsr_in;
                    quot_reg[k] <= {quot_in[tgv_pkg::QUOT_W-2:0], take};
                end
            end
        end
    endgenerate

    assign quotient = quot_reg[STEPS-1];

endmodule

// ===== hdl/torus_grid_vertex_generator.sv =====
`timescale 1ns / 1ps

// Torus vertex generator: one grid point (col_index, row_index) in, one vertex
// (position, normal, texture coordinates) out. Fully pipelined, one transaction
// per cycle unless the output stalls: two bit-per-stage dividers form u and v,
// then sine lookup, interpolation, two multiply stages, output register. A stall
// on the output freezes the whole pipe. The user must write configuration over
// the APB port only while no transaction is in flight; nothing enforces it.
module torus_grid_vertex_generator
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                grid_valid,
    output logic                grid_stall,
    input  logic [10:0]         col_index,
    input  logic [10:0]         row_index,
    output logic                vert_valid,
    input  logic                vert_stall,
    output logic signed [26:0]  pos_x,
    output logic signed [26:0]  pos_y,
    output logic signed [26:0]  pos_z,
    output logic signed [15:0]  norm_x,
    output logic signed [15:0]  norm_y,
    output logic signed [15:0]  norm_z,
    output logic [16:0]         tex_u,
    output logic [16:0]         tex_v,
    output logic                in_range
);

    localparam int DLAT = tgv_pkg::QUOT_W;

    logic [10:0] cols_reg, rows_reg;
    logic [15:0] major_reg, minor_reg;
    logic [10:0] cols_eff, rows_eff;
    logic        en;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg  <= 11'd32;
            rows_reg  <= 11'd16;
            major_reg <= 16'd512;
            minor_reg <= 16'd256;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                tgv_pkg::REG_COLUMNS: cols_reg  <= pwdata[10:0];
                tgv_pkg::REG_ROWS:    rows_reg  <= pwdata[10:0];
                tgv_pkg::REG_MAJOR:   major_reg <= pwdata[15:0];
                tgv_pkg::REG_MINOR:   minor_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tgv_pkg::REG_COLUMNS: prdata = {21'd0, cols_reg};
            tgv_pkg::REG_ROWS:    prdata = {21'd0, rows_reg};
            tgv_pkg::REG_MAJOR:   prdata = {16'd0, major_reg};
            tgv_pkg::REG_MINOR:   prdata = {16'd0, minor_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    assign cols_eff = (cols_reg == 11'd0) ? 11'd1
                    : (cols_reg > 11'(tgv_pkg::MAX_DIVISIONS)) ? 11'(tgv_pkg::MAX_DIVISIONS)
                    : cols_reg;
    assign rows_eff = (rows_reg == 11'd0) ? 11'd1
                    : (rows_reg > 11'(tgv_pkg::MAX_DIVISIONS)) ? 11'(tgv_pkg::MAX_DIVISIONS)
                    : rows_reg;

    assign en         = !(vert_valid && vert_stall);
    assign grid_stall = !en;

    // dividers
    logic [26:0] col_num, row_num;
    logic [16:0] u_quot, v_quot;

    assign col_num = {col_index, 16'd0} + 27'(cols_eff[10:1]);
    assign row_num = {row_index, 16'd0} + 27'(rows_eff[10:1]);

    tgv_div u_div_col
    (
        .clk      (clk),
        .en       (en),
        .dividend (col_num),
        .divisor  (cols_eff),
        .quotient (u_quot)
    );

    tgv_div u_div_row
    (
        .clk      (clk),
        .en       (en),
        .dividend (row_num),
        .divisor  (rows_eff),
        .quotient (v_quot)
    );

    logic [DLAT-1:0] dv_reg;
    logic [DLAT-1:0] dr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= '0;
        else if (en)
            dv_reg <= {dv_reg[DLAT-2:0], grid_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dr_reg <= {dr_reg[DLAT-2:0],
                       (col_index <= cols_eff) && (row_index <= rows_eff)};
    end

    // lookup stage
    logic [15:0]   pmaj, pmin;
    logic          lk_valid_reg;
    tgv_pkg::lk_t  lk_cmaj_reg, lk_smaj_reg, lk_cmin_reg, lk_smin_reg;
    tgv_pkg::side_t lk_side_reg;

    assign pmaj = u_quot[15:0];
    assign pmin = 16'h8000 - v_quot[15:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lk_cmaj_reg          <= tgv_pkg::sine_lookup(pmaj + 16'h4000);
            lk_smaj_reg          <= tgv_pkg::sine_lookup(pmaj);
            lk_cmin_reg          <= tgv_pkg::sine_lookup(pmin + 16'h4000);
            lk_smin_reg          <= tgv_pkg::sine_lookup(pmin);
            lk_side_reg.in_range <= dr_reg[DLAT-1];
            lk_side_reg.u16      <= u_quot;
            lk_side_reg.v16      <= v_quot;
        end
    end

    // interpolation stage
    function automatic logic signed [16:0] interp(input tgv_pkg::lk_t l);
        logic [21:0] p;
        logic [16:0] m;
        p = l.diff[15:0] * l.frac;
        m = {1'b0, l.a} + 17'((p + 22'd32) >> 6);
        return l.neg ? -$signed(m) : $signed(m);
    endfunction

    logic                  it_valid_reg;
    logic signed [16:0]    cmaj_reg, smaj_reg, cmin_reg, smin_reg;
    tgv_pkg::side_t        it_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmaj_reg    <= interp(lk_cmaj_reg);
            smaj_reg    <= interp(lk_smaj_reg);
            cmin_reg    <= interp(lk_cmin_reg);
            smin_reg    <= interp(lk_smin_reg);
            it_side_reg <= lk_side_reg;
        end
    end

    // first products
    logic                  p1_valid_reg;
    logic signed [33:0]    ring_reg, pz_prod_reg, nx_prod_reg, ny_prod_reg;
    logic signed [16:0]    p1_cmaj_reg, p1_smaj_reg, p1_smin_reg;
    tgv_pkg::side_t        p1_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ring_reg    <= $signed({2'b00, major_reg, 15'd0}) +
                           ($signed({1'b0, minor_reg}) * cmin_reg);
            pz_prod_reg <= $signed({1'b0, minor_reg}) * smin_reg;
            nx_prod_reg <= cmaj_reg * cmin_reg;
            ny_prod_reg <= smaj_reg * cmin_reg;
            p1_cmaj_reg <= cmaj_reg;
            p1_smaj_reg <= smaj_reg;
            p1_smin_reg <= smin_reg;
            p1_side_reg <= it_side_reg;
        end
    end

    // second products
    logic                  p2_valid_reg;
    logic signed [50:0]    px_prod_reg, py_prod_reg;
    logic signed [33:0]    p2_pz_reg, p2_nx_reg, p2_ny_reg;
    logic signed [16:0]    p2_smin_reg;
    tgv_pkg::side_t        p2_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_prod_reg <= ring_reg * p1_cmaj_reg;
            py_prod_reg <= ring_reg * p1_smaj_reg;
            p2_pz_reg   <= pz_prod_reg;
            p2_nx_reg   <= nx_prod_reg;
            p2_ny_reg   <= ny_prod_reg;
            p2_smin_reg <= p1_smin_reg;
            p2_side_reg <= p1_side_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_valid_reg <= 1'b0;
            it_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            vert_valid   <= 1'b0;
        end
        else if (en)
        begin
            lk_valid_reg <= dv_reg[DLAT-1];
            it_valid_reg <= lk_valid_reg;
            p1_valid_reg <= it_valid_reg;
            p2_valid_reg <= p1_valid_reg;
            vert_valid   <= p2_valid_reg;
        end
    end

    // round half up, saturate
    function automatic logic signed [26:0] sat_pos(input logic signed [51:0] v);
        if (v > 52'sd67108863)
            return 27'sd67108863;
        else if (v < -52'sd67108864)
            return -27'sd67108864;
        else
            return v[26:0];
    endfunction

    function automatic logic signed [15:0] sat_norm(input logic signed [51:0] v);
        if (v > 52'sd32767)
            return 16'sd32767;
        else if (v < -52'sd32768)
            return -16'sd32768;
        else
            return v[15:0];
    endfunction

    logic signed [51:0] px_r, py_r, pz_r, nx_r, ny_r;
    logic               ok;

    assign px_r = (52'(px_prod_reg) + 52'sd2097152) >>> 22;
    assign py_r = (52'(py_prod_reg) + 52'sd2097152) >>> 22;
    assign pz_r = (52'(p2_pz_reg) + 52'sd64) >>> 7;
    assign nx_r = (52'(p2_nx_reg) + 52'sd16384) >>> 15;
    assign ny_r = (52'(p2_ny_reg) + 52'sd16384) >>> 15;
    assign ok   = p2_side_reg.in_range;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x    <= ok ? sat_pos(px_r) : '0;
            pos_y    <= ok ? sat_pos(py_r) : '0;
            pos_z    <= ok ? sat_pos(pz_r) : '0;
            norm_x   <= ok ? sat_norm(nx_r) : '0;
            norm_y   <= ok ? sat_norm(ny_r) : '0;
            norm_z   <= ok ? p2_smin_reg[15:0] : '0;
            tex_u    <= ok ? (17'd65536 - p2_side_reg.u16) : '0;
            tex_v    <= ok ? p2_side_reg.v16 : '0;
            in_range <= ok;
        end
    end

endmodule

// ===== hdl/tgv_checker.sv =====
`timescale 1ns / 1ps

module tgv_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                vert_valid,
    input  logic                vert_stall,
    input  logic signed [26:0]  pos_x,
    input  logic signed [26:0]  pos_z,
    input  logic signed [15:0]  norm_x,
    input  logic [16:0]         tex_u,
    input  logic [16:0]         tex_v,
    input  logic                in_range
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && vert_stall |=> vert_valid)
        else $error("vertex dropped under stall");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && vert_stall |=> $stable(pos_x) && $stable(tex_u))
        else $error("vertex changed under stall");

    a_out_of_grid: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && !in_range |-> pos_x == 0 && pos_z == 0 && norm_x == 0
                                    && tex_u == 0 && tex_v == 0)
        else $error("out-of-grid vertex not cleared");

    a_tex_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vert_valid && in_range |-> tex_u <= 17'd65536 && tex_v <= 17'd65536)
        else $error("texture coordinate beyond 1.0");

endmodule

bind torus_grid_vertex_generator tgv_checker u_tgv_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .vert_valid (vert_valid),
    .vert_stall (vert_stall),
    .pos_x      (pos_x),
    .pos_z      (pos_z),
    .norm_x     (norm_x),
    .tex_u      (tex_u),
    .tex_v      (tex_v),
    .in_range   (in_range)
);

// ===== bench/torus_grid_vertex_generator_tb.sv =====
`timescale 1ns / 1ps

module torus_grid_vertex_generator_tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_WAIT = 30;

    typedef struct packed {
        logic signed [26:0] pos_x;
        logic signed [26:0] pos_y;
        logic signed [26:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic               in_range;
    } vertex_t;

    typedef struct {
        int      col;
        int      row;
        bit      typed;
        vertex_t vtx;
    } grid_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               grid_valid = 1'b0;
    logic               grid_stall;
    logic [10:0]        col_index = '0;
    logic [10:0]        row_index = '0;
    logic               vert_valid;
    logic               vert_stall = 1'b0;
    logic signed [26:0] pos_x;
    logic signed [26:0] pos_y;
    logic signed [26:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               in_range;

    torus_grid_vertex_generator u_dut (.*);

    longint  sine_q15 [0:256];
    longint  cfg_cols = 32;
    longint  cfg_rows = 16;
    longint  cfg_major = 512;
    longint  cfg_minor = 256;
    vertex_t vertex_q [$];
    bit      typed_q [$];
    vertex_t typed_vtx_q [$];
    int      errors = 0;
    int      idle_cycles = 0;
    int      vert_count = 0;
    bit      calm = 1'b0;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        longint unsigned x, x2, term, s, q;
        for (int k = 0; k <= 256; k++)
        begin
            x    = (64'd1686629713 * 64'(k)) >> 8;
            x2   = (x * x) >> 30;
            term = x;
            s    = x;
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n & 1)
                    s = s - term;
                else
                    s = s + term;
            end
            q = (s + 64'd16384) >> 15;
            if (q > 32767)
                q = 32767;
            sine_q15[k] = q;
        end
    end

    function automatic longint quarter_sin(longint t);
        longint tn, idx, frac;
        tn   = t << 8;
        idx  = tn >> 14;
        frac = tn & 16'h3FFF;
        if (idx >= 256)
            return sine_q15[256];
        return sine_q15[idx] + (((sine_q15[idx + 1] - sine_q15[idx]) * frac + 8192) >> 14);
    endfunction

    function automatic longint phase_sin(longint p);
        longint pp, quad, offs, m;
        pp   = p & 16'hFFFF;
        quad = pp >> 14;
        offs = pp & 16'h3FFF;
        m    = (quad & 1) ? quarter_sin(16384 - offs) : quarter_sin(offs);
        return (quad & 2) ? -m : m;
    endfunction

    function automatic longint rshift_round(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint eff_div(longint r);
        if (r == 0)
            return 1;
        if (r > tgv_pkg::MAX_DIVISIONS)
            return tgv_pkg::MAX_DIVISIONS;
        return r;
    endfunction

    function automatic vertex_t torus_vertex(longint col, longint row);
        vertex_t v;
        longint  cols, rows, u16, v16, pmaj, pmin, cmaj, smaj, cmin, smin, ring;
        cols = eff_div(cfg_cols);
        rows = eff_div(cfg_rows);
        v    = '0;
        if (col > cols || row > rows)
            return v;
        u16  = ((col << 16) + cols / 2) / cols;
        v16  = ((row << 16) + rows / 2) / rows;
        pmaj = u16 & 16'hFFFF;
        pmin = (32768 + 65536 - (v16 & 16'hFFFF)) & 16'hFFFF;
        cmaj = phase_sin(pmaj + 16384);
        smaj = phase_sin(pmaj);
        cmin = phase_sin(pmin + 16384);
        smin = phase_sin(pmin);
        ring = (cfg_major << 15) + cfg_minor * cmin;
        v.pos_x    = 27'(sat(rshift_round(ring * cmaj, 22), -67108864, 67108863));
        v.pos_y    = 27'(sat(rshift_round(ring * smaj, 22), -67108864, 67108863));
        v.pos_z    = 27'(sat(rshift_round(cfg_minor * smin, 7), -67108864, 67108863));
        v.norm_x   = 16'(sat(rshift_round(cmaj * cmin, 15), -32768, 32767));
        v.norm_y   = 16'(sat(rshift_round(smaj * cmin, 15), -32768, 32767));
        v.norm_z   = 16'(smin);
        v.tex_u    = 17'(65536 - u16);
        v.tex_v    = 17'(v16);
        v.in_range = 1'b1;
        return v;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("vertex %0d %s: got %0d, want %0d", vert_count, field, got, want);
        errors++;
    endtask

    // monitor: predict on accepted grid transaction, check on accepted vertex
    always @(posedge clk)
    begin
        vertex_t w;
        vertex_t t;
        bit      is_typed;
        bit      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (grid_valid && !grid_stall)
            begin
                moved = 1'b1;
                vertex_q.insert(vertex_q.size(), torus_vertex(col_index, row_index));
            end
            if (vert_valid && !vert_stall)
            begin
                moved = 1'b1;
                if (vertex_q.size() == 0)
                    report("unexpected vertex", 1, 0);
                else
                begin
                    w = vertex_q.pop_front();
                    if (typed_q.size() != 0)
                    begin
                        is_typed = typed_q.pop_front();
                        if (is_typed)
                        begin
                            t = typed_vtx_q.pop_front();
                            if (t != w)
                                report("typed row", 0, 1);
                        end
                    end
                    if (pos_x != w.pos_x)
                        report("pos_x", pos_x, w.pos_x);
                    if (pos_y != w.pos_y)
                        report("pos_y", pos_y, w.pos_y);
                    if (pos_z != w.pos_z)
                        report("pos_z", pos_z, w.pos_z);
                    if (norm_x != w.norm_x)
                        report("norm_x", norm_x, w.norm_x);
                    if (norm_y != w.norm_y)
                        report("norm_y", norm_y, w.norm_y);
                    if (norm_z != w.norm_z)
                        report("norm_z", norm_z, w.norm_z);
                    if (tex_u != w.tex_u)
                        report("tex_u", tex_u, w.tex_u);
                    if (tex_v != w.tex_v)
                        report("tex_v", tex_v, w.tex_v);
                    if (in_range != w.in_range)
                        report("in_range", in_range, w.in_range);
                end
                vert_count++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("torus_grid_vertex_generator: mismatch");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off to back the pipe up
    initial
    begin
        int hold;
        bit held;
        held = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (!held && vert_count >= 400)
            begin
                held = 1'b1;
                hold = 300;
            end
            if (hold > 0)
            begin
                hold--;
                vert_stall <= 1'b1;
            end
            else
                vert_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 32);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tgv_pkg::REG_COLUMNS: cfg_cols  = val & 32'h7FF;
            tgv_pkg::REG_ROWS:    cfg_rows  = val & 32'h7FF;
            tgv_pkg::REG_MAJOR:   cfg_major = val & 32'hFFFF;
            tgv_pkg::REG_MINOR:   cfg_minor = val & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic send_grid(int col, int row);
        int gap;
        if (!calm && $urandom_range(0, 99) < 32)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            grid_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        grid_valid <= 1'b1;
        col_index  <= 11'(col);
        row_index  <= 11'(row);
        @(posedge clk);
        while (grid_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        grid_valid <= 1'b0;
        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic random_phase(int n, bit pause_mid);
        int lim_c, lim_r, c, r;
        lim_c = int'(eff_div(cfg_cols));
        lim_r = int'(eff_div(cfg_rows));
        for (int i = 0; i < n; i++)
        begin
            if (pause_mid && i == n / 2)
            begin
                @(negedge clk);
                grid_valid <= 1'b0;
                while (vertex_q.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(0, 99) < 85)
            begin
                c = $urandom_range(0, lim_c);
                r = $urandom_range(0, lim_r);
            end
            else
            begin
                c = $urandom_range(0, 2047);
                r = $urandom_range(0, 2047);
            end
            send_grid(c, r);
        end
        drain();
    endtask

    grid_row_t directed [$];
    int        cfg_set [5][4] = '{
        '{1, 1, 0, 0},
        '{1024, 1024, 65535, 65535},
        '{0, 0, 300, 200},
        '{2047, 1500, 65535, 0},
        '{32, 16, 512, 256}
    };

    initial
    begin
        vertex_t zero_v;
        zero_v = '0;
        directed = '{
            '{0, 0, 1'b0, zero_v},
            '{32, 16, 1'b0, zero_v},
            '{16, 8, 1'b0, zero_v},
            '{8, 4, 1'b0, zero_v},
            '{24, 12, 1'b0, zero_v},
            '{31, 15, 1'b0, zero_v},
            '{1, 1, 1'b0, zero_v},
            '{0, 16, 1'b0, zero_v},
            '{32, 0, 1'b0, zero_v},
            '{33, 0, 1'b1, zero_v},
            '{0, 17, 1'b1, zero_v},
            '{2047, 2047, 1'b1, zero_v},
            '{1024, 1024, 1'b1, zero_v},
            '{1365, 682, 1'b1, zero_v}
        };
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            typed_q.insert(typed_q.size(), directed[i].typed);
            if (directed[i].typed)
                typed_vtx_q.insert(typed_vtx_q.size(), directed[i].vtx);
            send_grid(directed[i].col, directed[i].row);
        end
        drain();

        for (int p = 0; p < 5; p++)
        begin
            for (int k = 0; k < 4; k++)
                reg_write(k[1:0], cfg_set[p][k]);
            random_phase(20, 1'b0);
        end

        for (int p = 0; p < 6; p++)
        begin
            reg_write(tgv_pkg::REG_COLUMNS, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 2047) : $urandom_range(1, 64));
            reg_write(tgv_pkg::REG_ROWS, ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, 2047) : $urandom_range(1, 64));
            reg_write(tgv_pkg::REG_MAJOR, $urandom_range(0, 65535));
            reg_write(tgv_pkg::REG_MINOR, $urandom_range(0, 65535));
            calm = (p == 3);
            random_phase(240, p == 1);
        end
        calm = 1'b0;

        if (errors == 0)
            $display("torus_grid_vertex_generator: match");
        else
            $display("torus_grid_vertex_generator: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tgv_pkg.sv
hdl/tgv_div.sv
hdl/torus_grid_vertex_generator.sv
hdl/tgv_checker.sv
bench/torus_grid_vertex_generator_tb.sv
